// ----- rtl/tsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// TSDF fusion package
// Shared widths, constants, register indexes and payload types.
// ----------------------------------------------------------------------------
package tsdf_pkg;

   localparam int VOXELS_DEFAULT     = 65536;
   localparam int COLUMN_MAX_DEFAULT = 64;
   localparam int RANGE_W            = 20;
   localparam int INDEX_W            = 16;
   localparam int TSDF_W             = 16;
   localparam int WEIGHT_W           = 16;
   localparam int MASK_W             = 64;
   localparam int CSR_ADDR_W         = 2;
   localparam int CSR_DATA_W         = 20;
   localparam int COLLEN_W           = 7;
   localparam int Q_ONE              = 16384;

   localparam logic [CSR_ADDR_W-1:0] REG_MU     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DNEG   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_COLLEN = 2'd2;

   localparam logic CMD_INTEGRATE = 1'b0;
   localparam logic CMD_SCAN      = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [INDEX_W-1:0]   voxel_index;
      logic [RANGE_W-1:0]   model_range;
      logic [RANGE_W-1:0]   measured_range;
      logic                 depth_zero;
      logic                 assigned_elsewhere;
   } req_type;

   typedef struct packed {
      logic                 updated;
      logic signed [15:0]   tsdf_value;
      logic [15:0]          weight_value;
      logic [MASK_W-1:0]    surface_mask;
   } rsp_type;

   typedef struct packed {
      logic [RANGE_W-1:0]   mu;
      logic                 depth_negative;
      logic [COLLEN_W-1:0]  column_length;
   } cfg_type;

endpackage

// ----- rtl/tsdf_if.sv -----
// ----------------------------------------------------------------------------
// TSDF stream interfaces
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface tsdf_req_if;
   logic               valid;
   logic               ready;
   tsdf_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tsdf_rsp_if;
   logic               valid;
   logic               ready;
   tsdf_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tsdf_div.sv -----
// ----------------------------------------------------------------------------
// TSDF serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsdf_div #(
   parameter int NUM_W = 35,
   parameter int DEN_W = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ----- rtl/tsdf_store.sv -----
// ----------------------------------------------------------------------------
// TSDF voxel store
// Value and weight memories, one read and one write port, registered read
// data, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module tsdf_store #(
   parameter int VOXELS = tsdf_pkg::VOXELS_DEFAULT,
   localparam int AW = $clog2(VOXELS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [AW-1:0]                 rd_addr,
   output logic [tsdf_pkg::TSDF_W-1:0]   rd_tsdf,
   output logic [tsdf_pkg::WEIGHT_W-1:0] rd_weight,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [tsdf_pkg::TSDF_W-1:0]   wr_tsdf,
   input  logic [tsdf_pkg::WEIGHT_W-1:0] wr_weight,
   output logic                          clearing
);
   logic [tsdf_pkg::TSDF_W-1:0]   tsdf_mem [VOXELS];
   logic [tsdf_pkg::WEIGHT_W-1:0] weight_mem [VOXELS];
   logic [AW-1:0] clr_addr_ff;
   logic          clr_ff;
   logic          we;
   logic [AW-1:0] wa;
   logic [tsdf_pkg::TSDF_W-1:0]   wt;
   logic [tsdf_pkg::WEIGHT_W-1:0] ww;

   always_comb begin
      we = wr_en;
      wa = wr_addr;
      wt = wr_tsdf;
      ww = wr_weight;
      if (clr_ff) begin
         we = 1'b1;
         wa = clr_addr_ff;
         wt = '0;
         ww = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(VOXELS - 1)) clr_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         tsdf_mem[wa] <= wt;
         weight_mem[wa] <= ww;
      end
      rd_tsdf <= tsdf_mem[rd_addr];
      rd_weight <= weight_mem[rd_addr];
   end

   assign clearing = clr_ff;

endmodule

// ----- rtl/tsdf_voxel_fusion_core.sv -----
// Integrate: ETA, a first serial divide, READ, a second rounding divide and WRITE,
// then the result is registered; a rejected item skips the second divide. Scan
// reads a column of length L voxel by voxel. One item at a time: a new item can be
// taken in the cycle after the previous result is registered.
// Reset: synchronous; the stores are cleared by a sweep over all VOXELS entries,
// during which no item is accepted. Registers return to mu 1024, sign plus, length 64.
// ----------------------------------------------------------------------------
// TSDF voxel fusion core
// Read-modify-write sequencer over the voxel store, with column scans and a shared serial divider.
// ----------------------------------------------------------------------------
module tsdf_voxel_fusion_core #(
   parameter int VOXELS     = tsdf_pkg::VOXELS_DEFAULT,
   parameter int COLUMN_MAX = tsdf_pkg::COLUMN_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   tsdf_req_if.sink                          req,
   tsdf_rsp_if.source                        rsp,
   input  logic                              csr_write_enable,
   input  logic [tsdf_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [tsdf_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   localparam int AW   = $clog2(VOXELS);
   localparam int NUMW = 35;
   localparam int JW   = 7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ETA, ST_DIV1, ST_READ, ST_DIV2, ST_WRITE,
      ST_SCAN_RD, ST_SCAN, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   tsdf_pkg::cfg_type cfg_ff;
   tsdf_pkg::req_type item_ff, item_in;
   tsdf_pkg::rsp_type out_ff, out_in;
   tsdf_pkg::rsp_type hold_ff, hold_in;
   logic out_valid_ff, out_valid_in;

   logic signed [21:0] eta_ff, eta_in;
   logic               acc_ff, acc_in;
   logic signed [15:0] t_ff, t_in;
   logic [JW-1:0]      j_ff, j_in;
   logic [JW-1:0]      len_ff, len_in;
   logic               neg_ff, neg_in;
   logic               have_ff, have_in;
   logic               psign_ff, psign_in;
   logic [5:0]         pj_ff, pj_in;
   logic [tsdf_pkg::MASK_W-1:0] mask_ff, mask_in;

   logic [AW-1:0] rd_addr, wr_addr;
   logic [tsdf_pkg::TSDF_W-1:0]   rd_tsdf, wr_tsdf;
   logic [tsdf_pkg::WEIGHT_W-1:0] rd_weight, wr_weight;
   logic wr_en, clearing;

   logic div_start, div_done;
   logic [NUMW-1:0] div_num, div_quot;
   logic [20:0] div_den;

   logic [19:0] mu_eff;
   logic signed [21:0] eta_raw, mu_s;
   logic [21:0] mag;
   logic [15:0] qsat;
   logic signed [15:0] tval;
   logic [16:0] wp1;
   logic signed [33:0] prod;
   logic [33:0] pmag;
   logic [15:0] rmag;
   logic signed [15:0] rval;
   logic [JW-1:0] len_cfg;

   tsdf_store #(.VOXELS(VOXELS)) u_store (
      .clock, .reset, .rd_addr, .rd_tsdf, .rd_weight,
      .wr_en, .wr_addr, .wr_tsdf, .wr_weight, .clearing
   );

   tsdf_div #(.NUM_W(NUMW), .DEN_W(21)) u_div (
      .clock, .reset, .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mu <= 20'd1024;
         cfg_ff.depth_negative <= 1'b0;
         cfg_ff.column_length <= 7'd64;
      end else if (csr_write_enable) begin
         case (csr_index)
            tsdf_pkg::REG_MU:     cfg_ff.mu <= csr_write_data;
            tsdf_pkg::REG_DNEG:   cfg_ff.depth_negative <= csr_write_data[0];
            tsdf_pkg::REG_COLLEN: cfg_ff.column_length <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !clearing;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      mu_eff = (cfg_ff.mu == '0) ? 20'd1 : cfg_ff.mu;
      mu_s = $signed({2'b00, mu_eff});
      eta_raw = cfg_ff.depth_negative
         ? $signed({2'b00, item_ff.measured_range}) - $signed({2'b00, item_ff.model_range})
         : $signed({2'b00, item_ff.model_range}) - $signed({2'b00, item_ff.measured_range});
      if (item_ff.depth_zero) eta_raw = mu_s + 22'sd1;
      mag = eta_raw[21] ? 22'(-eta_raw) : 22'(eta_raw);
      qsat = (div_quot > NUMW'(tsdf_pkg::Q_ONE)) ? 16'(tsdf_pkg::Q_ONE) : div_quot[15:0];
      tval = $signed(rd_tsdf);
      wp1 = {1'b0, rd_weight} + 17'd1;
      prod = $signed({1'b0, rd_weight}) * tval + 34'(t_ff);
      pmag = prod[33] ? 34'(-prod) : 34'(prod);
      rmag = div_quot[15:0];
      rval = neg_ff ? 16'(-$signed(rmag)) : $signed(rmag);
      len_cfg = (cfg_ff.column_length == '0) ? JW'(1) :
                (cfg_ff.column_length > JW'(COLUMN_MAX)) ? JW'(COLUMN_MAX) :
                cfg_ff.column_length;
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      out_in = out_ff;
      hold_in = hold_ff;
      out_valid_in = out_valid_ff;
      eta_in = eta_ff;
      acc_in = acc_ff;
      t_in = t_ff;
      j_in = j_ff;
      len_in = len_ff;
      neg_in = neg_ff;
      have_in = have_ff;
      psign_in = psign_ff;
      pj_in = pj_ff;
      mask_in = mask_ff;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      rd_addr = AW'(item_ff.voxel_index);
      wr_en = 1'b0;
      wr_addr = AW'(item_ff.voxel_index);
      wr_tsdf = rval;
      wr_weight = (rd_weight == 16'hFFFF) ? rd_weight : wp1[15:0];
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.data;
               j_in = '0;
               have_in = 1'b0;
               mask_in = '0;
               len_in = len_cfg;
               state_in = (req.data.cmd == tsdf_pkg::CMD_SCAN) ? ST_SCAN_RD : ST_ETA;
            end
         end
         ST_ETA: begin
            eta_in = eta_raw;
            acc_in = ((eta_raw > -mu_s) && !item_ff.assigned_elsewhere) ||
                     ((eta_raw < -mu_s) && item_ff.assigned_elsewhere);
            state_in = ST_DIV1;
            div_start = 1'b1;
            div_num = NUMW'({mag, 14'd0});
            div_den = {1'b0, mu_eff};
         end
         ST_DIV1: begin
            if (div_done) begin
               t_in = eta_ff[21] ? 16'(-$signed({1'b0, qsat})) :
                      (eta_ff == '0 ? 16'sd0 : $signed(qsat));
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_DIV2;
         ST_DIV2: begin
            // rounding divide: (|p| + (w+1)/2) / (w+1)
            if (acc_ff) begin
               div_start = 1'b1;
               div_num = NUMW'(pmag + 34'(wp1 >> 1));
               div_den = {4'd0, wp1};
               neg_in = prod[33];
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!acc_ff || div_done) begin
               wr_en = acc_ff;
               hold_in = '0;
               hold_in.updated = acc_ff;
               hold_in.tsdf_value = acc_ff ? rval : tval;
               hold_in.weight_value = acc_ff ? wr_weight : rd_weight;
               state_in = ST_OUT;
            end
         end
         ST_SCAN_RD: begin
            rd_addr = AW'(32'(item_ff.voxel_index) + 32'(j_ff));
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_weight != '0 && rd_tsdf != '0) begin
               if (have_ff && psign_ff != rd_tsdf[tsdf_pkg::TSDF_W-1]) mask_in[pj_ff] = 1'b1;
               have_in = 1'b1;
               psign_in = rd_tsdf[tsdf_pkg::TSDF_W-1];
               pj_in = j_ff[5:0];
            end
            j_in = j_ff + 1'b1;
            if (j_in == len_ff) begin
               hold_in = '0;
               hold_in.surface_mask = mask_in;
               state_in = ST_OUT;
            end else begin
               rd_addr = AW'(32'(item_ff.voxel_index) + 32'(j_in));
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in = hold_ff;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff <= out_in;
      hold_ff <= hold_in;
      eta_ff <= eta_in;
      acc_ff <= acc_in;
      t_ff <= t_in;
      j_ff <= j_in;
      len_ff <= len_in;
      neg_ff <= neg_in;
      psign_ff <= psign_in;
      pj_ff <= pj_in;
      mask_ff <= mask_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         have_ff <= have_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (state_ff == ST_IDLE)) else $error("ready outside idle");
   a_no_clear_accept: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req.ready) else $error("accept during clear");
   a_write_only_acc: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> acc_ff) else $error("write without accept");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
      else $error("response dropped while stalled");

endmodule
